// ===== rtl/core/stl_pkg.sv =====
package stl_pkg;

    // character codes
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;

    // command codes
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_EOI  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_3 = 2'd3;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_TOKEN   = 4'b0100,
        MODE_LITERAL = 4'b1000
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] token_char;
        logic       first_of_token;
        logic       last_of_token;
        logic       from_literal;
        logic       empty_token;
    } res_t;

    // results caused by one byte; r0 always valid in a queued entry
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    function automatic res_t make_res(logic [7:0] ch, logic first, logic last,
                                      logic lit, logic empty);
        res_t r;
        r.token_char     = ch;
        r.first_of_token = first;
        r.last_of_token  = last;
        r.from_literal   = lit;
        r.empty_token    = empty;
        return r;
    endfunction

endpackage

// ===== rtl/core/stl_in_if.sv =====
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_in;

    modport source (output valid, output command, output char_in, input ready);
    modport sink   (input valid, input command, input char_in, output ready);
endinterface

// ===== rtl/core/stl_out_if.sv =====
interface stl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] token_char;
    logic       first_of_token;
    logic       last_of_token;
    logic       from_literal;
    logic       empty_token;

    modport source (output valid, output token_char, output first_of_token,
                    output last_of_token, output from_literal, output empty_token,
                    input ready);
    modport sink   (input valid, input token_char, input first_of_token,
                    input last_of_token, input from_literal, input empty_token,
                    output ready);
endinterface

// ===== rtl/core/stl_cfg_if.sv =====
interface stl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/script_token_lexer.sv =====
// channel | role   | beat moves                          | handshake
// src     | sink   | command, char_in                    | valid & ready
// dst     | source | token_char, first/last, lit, empty  | valid & ready
// cfg     | sink   | index (special_set_0..3), data      | valid & ready (ready tied high)
//
// one text byte per cycle is taken while the result queue has room; the
// byte's state update and its results are written at the edge of its beat,
// so its first result, if no older entry is queued, is offered on dst in the
// cycle right after that edge; the result port gives one beat per cycle while
// dst is ready, so a byte causing two results takes two beats; sustained rate
// is one byte per cycle unless results outrun the port, then one result per cycle
// reset clears lexer state, special sets and the queue; no clearing pass
// dst stalls fill the queue, then src ready drops; src idling never blocks dst
module script_token_lexer
    import stl_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    stl_in_if.sink        src,
    stl_out_if.source     dst,
    stl_cfg_if.sink       cfg
);

    // front to queue
    logic   push;
    entry_t push_entry;
    logic   q_full;

    // queue to back
    logic   q_empty;
    logic   pop;
    entry_t head;
    res_t   out_res;

    // special sets are always writable
    assign cfg.ready = 1'b1;

    // front: classifies the byte, updates the token state, forms results
    stl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (src.valid),
        .in_ready   (src.ready),
        .command    (src.command),
        .char_in    (src.char_in),
        .cfg_valid  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // short queue of per-byte result entries, decouples front and back
    stl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (head)
    );

    // back: hands out the one or two results of each entry in order
    stl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (dst.valid),
        .out_ready (dst.ready),
        .out_res   (out_res)
    );

    assign dst.token_char     = out_res.token_char;
    assign dst.first_of_token = out_res.first_of_token;
    assign dst.last_of_token  = out_res.last_of_token;
    assign dst.from_literal   = out_res.from_literal;
    assign dst.empty_token    = out_res.empty_token;

endmodule

// ===== rtl/core/stl_front.sv =====
module stl_front
    import stl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [7:0]           char_in,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 q_full,
    output logic                 push,
    output entry_t               push_entry
);

    lex_mode_t   mode_reg, mode_next;
    logic [7:0]  held_char_reg, held_char_next;
    logic        held_valid_reg, held_valid_next;
    logic        held_first_reg, held_first_next;
    logic        numeric_reg, numeric_next;
    logic        escape_reg, escape_next;
    logic [63:0] special_reg [4];

    logic [255:0] special_map;
    logic         accept;
    logic         is_sp, is_ws, is_num, tok_end;
    logic         v0, v1;
    res_t         r0, r1;

    assign special_map = {special_reg[3], special_reg[2], special_reg[1], special_reg[0]};
    assign is_sp  = special_map[char_in];
    assign is_ws  = (char_in == CH_SPACE) || (char_in == CH_TAB) || (char_in == CH_NL)
                 || (char_in == CH_VT) || (char_in == CH_FF) || (char_in == CH_CR);
    assign is_num = (char_in == CH_MINUS) || ((char_in >= CH_ZERO) && (char_in <= CH_NINE));
    assign tok_end = is_sp || is_ws || ((char_in == CH_DOT) && !numeric_reg);

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic bt;
        logic [7:0] esc_ch;
        logic esc_hit;
        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        numeric_next    = numeric_reg;
        escape_next     = escape_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        r0 = '0;
        r1 = '0;
        bt = 1'b0;
        esc_ch  = CH_BSLASH;
        esc_hit = 1'b1;

        if (command == CMD_EOI)
        begin
            if (held_valid_reg)
            begin
                v0 = 1'b1;
                r0 = make_res(held_char_reg, held_first_reg, 1'b1,
                              mode_reg == MODE_LITERAL, 1'b0);
            end
            mode_next       = MODE_IDLE;
            held_char_next  = '0;
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
            numeric_next    = 1'b0;
            escape_next     = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    bt = 1'b1;
                end
                MODE_COMMENT:
                begin
                    if (char_in == CH_NL)
                        mode_next = MODE_IDLE;
                end
                MODE_TOKEN:
                begin
                    if (tok_end)
                    begin
                        if (held_valid_reg)
                        begin
                            v0 = 1'b1;
                            r0 = make_res(held_char_reg, held_first_reg, 1'b1, 1'b0, 1'b0);
                        end
                        held_valid_next = 1'b0;
                        mode_next       = MODE_IDLE;
                        bt              = 1'b1;
                    end
                    else
                    begin
                        // emit held, hold the new byte
                        if (held_valid_reg)
                        begin
                            v0 = 1'b1;
                            r0 = make_res(held_char_reg, held_first_reg, 1'b0, 1'b0, 1'b0);
                        end
                        held_first_next = !held_valid_reg;
                        held_char_next  = char_in;
                        held_valid_next = 1'b1;
                    end
                end
                MODE_LITERAL:
                begin
                    case (char_in)
                        CH_BSLASH:  esc_ch = CH_BSLASH;
                        CH_LOWER_T: esc_ch = CH_TAB;
                        CH_LOWER_N: esc_ch = CH_NL;
                        CH_LOWER_R: esc_ch = CH_CR;
                        CH_QUOTE:   esc_ch = CH_QUOTE;
                        default:    esc_hit = 1'b0;
                    endcase
                    if (escape_reg && held_valid_reg)
                    begin
                        escape_next = 1'b0;
                        if (esc_hit)
                            held_char_next = esc_ch;
                        else
                        begin
                            v0 = 1'b1;
                            r0 = make_res(held_char_reg, held_first_reg, 1'b0, 1'b1, 1'b0);
                            held_first_next = 1'b0;
                            held_char_next  = char_in;
                        end
                    end
                    else if (char_in == CH_QUOTE)
                    begin
                        v0 = 1'b1;
                        if (held_valid_reg)
                            r0 = make_res(held_char_reg, held_first_reg, 1'b1, 1'b1, 1'b0);
                        else
                            r0 = make_res(8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
                        held_valid_next = 1'b0;
                        escape_next     = 1'b0;
                        mode_next       = MODE_IDLE;
                    end
                    else
                    begin
                        if (held_valid_reg)
                        begin
                            v0 = 1'b1;
                            r0 = make_res(held_char_reg, held_first_reg, 1'b0, 1'b1, 1'b0);
                        end
                        held_first_next = !held_valid_reg;
                        held_char_next  = char_in;
                        held_valid_next = 1'b1;
                        escape_next     = (char_in == CH_BSLASH);
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            // byte seen between tokens
            if (bt)
            begin
                if (char_in == CH_SEMI)
                    mode_next = MODE_COMMENT;
                else if (char_in == CH_QUOTE)
                begin
                    mode_next       = MODE_LITERAL;
                    held_valid_next = 1'b0;
                    escape_next     = 1'b0;
                end
                else if (is_sp || (char_in == CH_DOT))
                begin
                    if (v0)
                    begin
                        v1 = 1'b1;
                        r1 = make_res(char_in, 1'b1, 1'b1, 1'b0, 1'b0);
                    end
                    else
                    begin
                        v0 = 1'b1;
                        r0 = make_res(char_in, 1'b1, 1'b1, 1'b0, 1'b0);
                    end
                end
                else if (!is_ws)
                begin
                    mode_next       = MODE_TOKEN;
                    held_char_next  = char_in;
                    held_valid_next = 1'b1;
                    held_first_next = 1'b1;
                    numeric_next    = is_num;
                end
            end
        end
    end

    assign push            = accept && v0;
    assign push_entry.two  = v1;
    assign push_entry.r0   = r0;
    assign push_entry.r1   = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            numeric_reg    <= 1'b0;
            escape_reg     <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            held_first_reg <= held_first_next;
            numeric_reg    <= numeric_next;
            escape_reg     <= escape_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            special_reg[0] <= '0;
            special_reg[1] <= '0;
            special_reg[2] <= '0;
            special_reg[3] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SPECIAL_0: special_reg[0] <= cfg_data;
                CFG_SPECIAL_1: special_reg[1] <= cfg_data;
                CFG_SPECIAL_2: special_reg[2] <= cfg_data;
                CFG_SPECIAL_3: special_reg[3] <= cfg_data;
                default:       special_reg[0] <= special_reg[0];
            endcase
        end
    end

endmodule

// ===== rtl/core/stl_queue.sv =====
module stl_queue
    import stl_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== rtl/core/stl_back.sv =====
module stl_back
    import stl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   empty,
    input  entry_t head,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_ready,
    output res_t   out_res
);

    // which result of the head entry goes next
    logic sel_reg, sel_next;
    logic beat;

    assign out_valid = !empty;
    assign out_res   = sel_reg ? head.r1 : head.r0;
    assign beat      = out_valid && out_ready;
    assign pop       = beat && (sel_reg || !head.two);

    always_comb
    begin
        sel_next = sel_reg;
        if (beat)
            sel_next = !pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import stl_pkg::*;

    // extra one-char tokens used by the directed and pressure parts
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // cycles with no beat on any channel before the run is given up
    localparam int unsigned STALL_LIMIT   = 3000;
    // quiet cycles after the last expected beat, covers bytes with no result
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 120;

    logic clk;
    logic rst_n;

    stl_in_if  src_bus ();
    stl_out_if dst_bus ();
    stl_cfg_if cfg_bus ();

    script_token_lexer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_bus),
        .dst   (dst_bus),
        .cfg   (cfg_bus)
    );

    // mirror of the lexer: special sets and per-byte state
    logic [63:0] special_map [4];
    lex_mode_t   lex_mode;
    logic [7:0]  held_ch;
    bit          held_ok;
    bit          held_first;
    bit          num_lead;
    bit          esc_wait;

    // token characters still owed by the block, oldest first
    res_t token_q [$];

    // sender and receiver pacing
    bit          tx_steady;
    int unsigned burst_left;
    int unsigned hold_req;
    int unsigned hold_left;
    int unsigned rx_stall_pct;
    int unsigned rx_phase_left;

    // bookkeeping
    int unsigned err_count;
    int unsigned quiet_cycles;
    int unsigned text_bytes;
    int unsigned eoi_count;
    int unsigned beats_checked;
    int unsigned pair_count;
    int unsigned literal_count;
    int unsigned cfg_writes;
    bit          beat_seen;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // lexer prediction
    // ------------------------------------------------------------------

    function automatic bit special_byte(logic [7:0] c);
        return special_map[c[7:6]][c[5:0]];
    endfunction

    function automatic bit blank_byte(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL ||
               c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic void put_token_char(logic [7:0] c, bit first, bit last,
                                           bit lit, bit empty);
        res_t r;
        r.token_char     = c;
        r.first_of_token = first;
        r.last_of_token  = last;
        r.from_literal   = lit;
        r.empty_token    = empty;
        token_q.push_back(r);
        if (empty)
            literal_count++;
    endfunction

    // release the delayed character and keep c in its place
    function automatic void shift_held(logic [7:0] c, bit lit);
        if (held_ok)
        begin
            put_token_char(held_ch, held_first, 1'b0, lit, 1'b0);
            held_first = 1'b0;
        end
        else
            held_first = 1'b1;
        held_ch = c;
        held_ok = 1'b1;
    endfunction

    // byte seen while no token is open
    function automatic void take_between(logic [7:0] c);
        if (c == CH_SEMI)
            lex_mode = MODE_COMMENT;
        else if (c == CH_QUOTE)
        begin
            lex_mode = MODE_LITERAL;
            held_ok  = 1'b0;
            esc_wait = 1'b0;
        end
        else if (special_byte(c) || c == CH_DOT)
            put_token_char(c, 1'b1, 1'b1, 1'b0, 1'b0);
        else if (!blank_byte(c))
        begin
            lex_mode   = MODE_TOKEN;
            held_ch    = c;
            held_ok    = 1'b1;
            held_first = 1'b1;
            num_lead   = (c == CH_MINUS) || (c >= CH_ZERO && c <= CH_NINE);
        end
    endfunction

    function automatic void lex_predict(logic cmd, logic [7:0] c);
        int unsigned before_cnt;
        before_cnt = token_q.size();
        if (cmd == CMD_EOI)
        begin
            // flush whatever is held, literal or not
            if (held_ok)
                put_token_char(held_ch, held_first, 1'b1, lex_mode == MODE_LITERAL, 1'b0);
            lex_mode   = MODE_IDLE;
            held_ch    = 8'h00;
            held_ok    = 1'b0;
            held_first = 1'b0;
            num_lead   = 1'b0;
            esc_wait   = 1'b0;
            eoi_count++;
        end
        else
        begin
            case (lex_mode)
                MODE_IDLE:
                    take_between(c);
                MODE_COMMENT:
                    if (c == CH_NL)
                        lex_mode = MODE_IDLE;
                MODE_TOKEN:
                    if (special_byte(c) || blank_byte(c) || (c == CH_DOT && !num_lead))
                    begin
                        // the ending byte is then taken as between tokens
                        if (held_ok)
                            put_token_char(held_ch, held_first, 1'b1, 1'b0, 1'b0);
                        held_ok  = 1'b0;
                        lex_mode = MODE_IDLE;
                        take_between(c);
                    end
                    else
                        shift_held(c, 1'b0);
                default:
                    if (esc_wait && held_ok)
                    begin
                        // a known escape rewrites the held backslash in place, any other byte releases it
                        esc_wait = 1'b0;
                        case (c)
                            CH_BSLASH:  held_ch = CH_BSLASH;
                            CH_LOWER_T: held_ch = CH_TAB;
                            CH_LOWER_N: held_ch = CH_NL;
                            CH_LOWER_R: held_ch = CH_CR;
                            CH_QUOTE:   held_ch = CH_QUOTE;
                            default:    shift_held(c, 1'b1);
                        endcase
                    end
                    else if (c == CH_QUOTE)
                    begin
                        if (held_ok)
                        begin
                            put_token_char(held_ch, held_first, 1'b1, 1'b1, 1'b0);
                            literal_count++;
                        end
                        else
                            put_token_char(8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
                        held_ok  = 1'b0;
                        esc_wait = 1'b0;
                        lex_mode = MODE_IDLE;
                    end
                    else
                    begin
                        shift_held(c, 1'b1);
                        esc_wait = (c == CH_BSLASH);
                    end
            endcase
        end
        if (token_q.size() - before_cnt == 2)
            pair_count++;
    endfunction

    // ------------------------------------------------------------------
    // monitor: predicts on input beats, checks output beats, watchdog
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_token_beat();
        res_t want;
        if (token_q.size() == 0)
        begin
            $error("token_char: expected no beat, got %h", dst_bus.token_char);
            err_count++;
        end
        else
        begin
            want = token_q.pop_front();
            check_field("token_char", want.token_char, dst_bus.token_char);
            check_field("first_of_token", 8'(want.first_of_token),
                        8'(dst_bus.first_of_token));
            check_field("last_of_token", 8'(want.last_of_token),
                        8'(dst_bus.last_of_token));
            check_field("from_literal", 8'(want.from_literal),
                        8'(dst_bus.from_literal));
            check_field("empty_token", 8'(want.empty_token),
                        8'(dst_bus.empty_token));
            beats_checked++;
        end
    endtask

    // one process handles every channel so prediction always precedes checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            beat_seen = 1'b0;
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                special_map[cfg_bus.index] = cfg_bus.data;
                cfg_writes++;
                beat_seen = 1'b1;
            end
            if (src_bus.valid && src_bus.ready)
            begin
                lex_predict(src_bus.command, src_bus.char_in);
                beat_seen = 1'b1;
            end
            if (dst_bus.valid && dst_bus.ready)
            begin
                check_token_beat();
                beat_seen = 1'b1;
            end
            if (beat_seen)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("watchdog: no beat for %0d cycles, %0d token chars owed",
                             quiet_cycles, token_q.size());
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern in phases, plus a long hold-off on request
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            dst_bus.ready <= 1'b0;
        end
        else
        begin
            if (rx_phase_left == 0)
            begin
                // stretches of no stalling are the most common phase
                case ($urandom_range(0, 4))
                    0, 1:    rx_stall_pct = 0;
                    2:       rx_stall_pct = 25;
                    3:       rx_stall_pct = 50;
                    default: rx_stall_pct = 80;
                endcase
                rx_phase_left = $urandom_range(8, 48);
            end
            rx_phase_left--;
            dst_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // one byte beat; valid stays high afterwards so bursts run back to back
    task automatic send_byte(logic cmd, logic [7:0] c);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = (tx_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                @(negedge clk);
                src_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        src_bus.valid   <= 1'b1;
        src_bus.command <= cmd;
        src_bus.char_in <= c;
        do
            @(posedge clk);
        while (!src_bus.ready);
        if (cmd == CMD_TEXT)
            text_bytes++;
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(CMD_TEXT, s[i]);
    endtask

    // char_in is a don't-care here, so it carries noise
    task automatic send_eoi();
        send_byte(CMD_EOI, 8'($urandom));
    endtask

    // drop valid, wait for every owed token char, then let the block go quiet
    task automatic settle_lexer();
        @(negedge clk);
        src_bus.valid <= 1'b0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_special(logic [1:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_all_special(logic [63:0] s0, logic [63:0] s1,
                                     logic [63:0] s2, logic [63:0] s3);
        write_special(CFG_SPECIAL_0, s0);
        write_special(CFG_SPECIAL_1, s1);
        write_special(CFG_SPECIAL_2, s2);
        write_special(CFG_SPECIAL_3, s3);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_NL;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_word_char();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // a special byte under the current sets if one turns up, else whitespace
    function automatic logic [7:0] pick_special();
        logic [7:0] c;
        for (int i = 0; i < 8; i++)
        begin
            c = 8'($urandom);
            if (special_map[c[7:6]][c[5:0]])
                return c;
        end
        return pick_blank();
    endfunction

    // one piece of script: mostly well-formed, some noise
    task automatic send_phrase();
        int unsigned kind;
        int unsigned len;
        logic [7:0]  c;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
            begin
                // identifier, then sometimes a separator of some kind
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(CMD_TEXT, ($urandom_range(0, 7) == 0) ? CH_DOT : pick_word_char());
                case ($urandom_range(0, 3))
                    0:       send_byte(CMD_TEXT, pick_blank());
                    1:       send_byte(CMD_TEXT, pick_special());
                    2:       send_byte(CMD_TEXT, CH_DOT);
                    default: ;
                endcase
            end
            3:
            begin
                // number, dots stay inside
                if ($urandom_range(0, 1) != 0)
                    send_byte(CMD_TEXT, CH_MINUS);
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_byte(CMD_TEXT, CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 1) != 0)
                begin
                    send_byte(CMD_TEXT, CH_DOT);
                    send_byte(CMD_TEXT, CH_ZERO + 8'($urandom_range(0, 9)));
                end
                send_byte(CMD_TEXT, ($urandom_range(0, 1) != 0) ? pick_blank() : pick_special());
            end
            4, 5:
            begin
                // literal with escapes, sometimes cut off by end of input
                send_byte(CMD_TEXT, CH_QUOTE);
                len = $urandom_range(0, 6);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        send_byte(CMD_TEXT, CH_BSLASH);
                        case ($urandom_range(0, 5))
                            0:       c = CH_BSLASH;
                            1:       c = CH_LOWER_T;
                            2:       c = CH_LOWER_N;
                            3:       c = CH_LOWER_R;
                            4:       c = CH_QUOTE;
                            default: c = 8'($urandom);
                        endcase
                        send_byte(CMD_TEXT, c);
                    end
                    else
                    begin
                        c = 8'($urandom);
                        send_byte(CMD_TEXT, (c == CH_QUOTE) ? CH_LOWER_N : c);
                    end
                end
                if ($urandom_range(0, 7) == 0)
                    send_eoi();
                else
                    send_byte(CMD_TEXT, CH_QUOTE);
            end
            6:
            begin
                send_byte(CMD_TEXT, CH_SEMI);
                len = $urandom_range(0, 5);
                for (int i = 0; i < len; i++)
                begin
                    c = 8'($urandom);
                    send_byte(CMD_TEXT, (c == CH_NL) ? CH_SEMI : c);
                end
                send_byte(CMD_TEXT, CH_NL);
            end
            7:
                send_byte(CMD_TEXT, pick_special());
            8:
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_byte(($urandom_range(0, 7) == 0) ? CMD_EOI : CMD_TEXT, 8'($urandom));
            end
            default:
                send_eoi();
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // parens and brackets as one-char tokens, 0xff special, others clear
    task automatic test_directed();
        write_all_special((64'd1 << CH_LPAREN) | (64'd1 << CH_RPAREN),
                          (64'd1 << (CH_LBRACK - 8'd64)) | (64'd1 << (CH_RBRACK - 8'd64)),
                          64'd0,
                          64'd1 << 63);
        // special token, zero byte as a token, dot ending a word then a dot
        // token, tab separator, numeric token keeping its dot, special
        // ending a token for two results in one byte
        send_byte(CMD_TEXT, CH_LPAREN);
        send_byte(CMD_TEXT, 8'h00);
        send_str(".b\t-1.5)");
        // empty comment
        send_str(";\n");
        // translated newline, kept unknown escape, translated backslash that
        // does not escape the closing quote
        send_str("\"\\n\\q\\\\\"");
        // empty literal
        send_str("\"\"");
        // top byte special, high byte as a token flushed by end of input
        send_byte(CMD_TEXT, 8'hFF);
        send_byte(CMD_TEXT, 8'h80);
        send_eoi();
        // trailing backslash in an open literal flushed by end of input
        send_str("\"\\");
        send_eoi();
        settle_lexer();
    endtask

    // receiver holds off while the sender keeps offering two-result pairs
    task automatic test_backpressure();
        tx_steady = 1'b1;
        hold_req  = HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
        begin
            send_byte(CMD_TEXT, pick_word_char() == CH_RPAREN ? 8'h61 : 8'h61);
            send_byte(CMD_TEXT, CH_RPAREN);
        end
        tx_steady = 1'b0;
        send_eoi();
        settle_lexer();
    endtask

    // random script under several special-set settings
    task automatic test_random_script();
        int unsigned start_bytes;
        int unsigned budget;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                    write_all_special(64'd0, 64'd0, 64'd0, 64'd0);
                1:
                    write_all_special({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
                2:
                    write_all_special({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
                                      {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
                                      {$urandom, $urandom} & {$urandom, $urandom},
                                      {$urandom, $urandom} & {$urandom, $urandom});
                default:
                    write_all_special({$urandom, $urandom}, {$urandom, $urandom},
                                      {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            // everything special leaves little to explore, keep it short
            budget = (phase == 1) ? 50 : 100;
            start_bytes = text_bytes;
            while (text_bytes - start_bytes < budget)
                send_phrase();
            send_eoi();
            settle_lexer();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        src_bus.valid    = 1'b0;
        src_bus.command  = CMD_TEXT;
        src_bus.char_in  = 8'h00;
        dst_bus.ready    = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_SPECIAL_0;
        cfg_bus.data     = 64'd0;
        for (int i = 0; i < 4; i++)
            special_map[i] = 64'd0;
        lex_mode      = MODE_IDLE;
        held_ch       = 8'h00;
        held_ok       = 1'b0;
        held_first    = 1'b0;
        num_lead      = 1'b0;
        esc_wait      = 1'b0;
        tx_steady     = 1'b0;
        burst_left    = 0;
        hold_req      = 0;
        hold_left     = 0;
        rx_stall_pct  = 0;
        rx_phase_left = 0;
        err_count     = 0;
        quiet_cycles  = 0;
        text_bytes    = 0;
        eoi_count     = 0;
        beats_checked = 0;
        pair_count    = 0;
        literal_count = 0;
        cfg_writes    = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_script();

        // tail: everything owed must show up, and nothing more
        @(negedge clk);
        src_bus.valid <= 1'b0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("covered: %0d text bytes, %0d end-of-input beats, %0d register writes",
                 text_bytes, eoi_count, cfg_writes);
        $display("checked: %0d token chars, %0d bytes with two results, %0d literal ends",
                 beats_checked, pair_count, literal_count);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== script_token_lexer.f =====
rtl/core/stl_pkg.sv
rtl/core/stl_in_if.sv
rtl/core/stl_out_if.sv
rtl/core/stl_cfg_if.sv
rtl/core/stl_front.sv
rtl/core/stl_queue.sv
rtl/core/stl_back.sv
rtl/core/script_token_lexer.sv
bench/tb_top.sv
